/* design/bfqd_pkg.sv */
// ----------------------------------------------------------------------------
// bfqd_pkg: shared types and constants of the bounded FIFO queue with dump
// Queue geometry, operation and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bfqd_pkg;

    localparam int DEPTH    = 32;
    localparam int DATA_W   = 32;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 6;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 32;
    // tdata of the result: data then occupancy, padded to whole bytes.
    localparam int M_FIELDS_W = VALUE_W + OCC_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_DUMP = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_OVF   = 2'd1,
        STAT_UNDF  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic    wr;          // store the request value at the tail
        logic    pop;         // read the head and retire it
        logic    dump_start;  // read the head and start a dump walk
        logic    dump_step;   // read the next slot of the dump walk
        logic    load;        // load the result register
        logic    from_mem;    // result data comes from the read port
        logic    last;
        status_t status;
    } bfqd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
        logic out_free;
    } bfqd_stat_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

/* design/bfqd_ctrl.sv */
// ----------------------------------------------------------------------------
// bfqd_ctrl: operation sequencer of the queue
// Decodes each request and steps dequeue and dump reads through the
// registered read port of the entry memory.
// ----------------------------------------------------------------------------
module bfqd_ctrl
    import bfqd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] req_kind,
    output logic              req_ready,
    input  bfqd_stat_t        stat,
    output bfqd_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    case (kind_t'(req_kind))
                        KIND_ENQ:
                        begin
                            cmd.wr     = !stat.full;
                            cmd.load   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.status = stat.full ? STAT_OVF : STAT_OK;
                        end
                        KIND_DEQ:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.last   = 1'b1;
                                cmd.status = STAT_UNDF;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_DEQ;
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.last   = 1'b1;
                                cmd.status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // Reserved operation: dropped without a result.
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                if (stat.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.from_mem = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.from_mem = 1'b1;
                    cmd.last     = stat.dump_last;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dump_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/bfqd_dpath.sv */
// ----------------------------------------------------------------------------
// bfqd_dpath: entry memory, pointers and result register of the queue
// Holds the circular buffer, head/tail/count, the dump walk pointer and the
// output register that drives the result channel.
// ----------------------------------------------------------------------------
module bfqd_dpath
    import bfqd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bfqd_cmd_t           cmd,
    input  logic [VALUE_W-1:0]  value,
    input  logic                out_ready,
    output bfqd_stat_t          stat,
    output logic                out_valid,
    output logic [STAT_W-1:0]   out_status,
    output logic [VALUE_W-1:0]  out_data,
    output logic [OCC_W-1:0]    out_occ,
    output logic                out_last
);

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;

    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   walk_reg;
    logic [PTR_W-1:0]   walk_next;
    logic [CNT_W-1:0]   remain_reg;
    logic [CNT_W-1:0]   remain_next;

    logic               valid_reg;
    logic               valid_next;
    logic [STAT_W-1:0]  status_reg;
    logic [VALUE_W-1:0] data_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic               last_reg;

    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_last = (remain_reg == CNT_W'(1));
    assign stat.out_free  = !valid_reg || out_ready;

    assign rd_en   = cmd.pop || cmd.dump_start || cmd.dump_step;
    assign rd_addr = cmd.dump_step ? walk_reg : head_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        remain_next = remain_reg;
        if (cmd.wr)
        begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.dump_start)
        begin
            walk_next   = next_slot(head_reg);
            remain_next = count_reg;
        end
        if (cmd.dump_step)
        begin
            walk_next   = next_slot(walk_reg);
            remain_next = remain_reg - CNT_W'(1);
        end
        valid_next = valid_reg && !out_ready;
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[tail_reg] <= value[DATA_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            walk_reg   <= '0;
            remain_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            remain_reg <= remain_next;
            valid_reg  <= valid_next;
        end
    end

    // Occupancy reflects the queue after the operation, so it takes the
    // count as it will be after this edge.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            data_reg   <= cmd.from_mem ? VALUE_W'($signed(rd_data_reg)) : '0;
            occ_reg    <= OCC_W'(count_next);
            last_reg   <= cmd.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_occ    = occ_reg;
    assign out_last   = last_reg;

endmodule

/* design/bounded_fifo_queue_with_dump.sv */
// ----------------------------------------------------------------------------
// bounded_fifo_queue_with_dump: 32-entry FIFO queue with a dump operation
// Top level joining the operation sequencer and the queue datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: tuser carries the operation (enqueue,
//   dequeue, dump), tdata the value to enqueue. Results leave on the m_
//   channel: tuser is the status, tdata holds the data and the occupancy,
//   and tlast marks the final result of a request.
//   An enqueue, and any request that fails or finds the queue empty, gives
//   its result in the cycle after acceptance and allows one request per cycle
//   unless the receiver stalls. A dequeue reads the head through the registered
//   read port of the entry memory before loading the result. A dump reads the
//   head to start the walk, then gives one result per cycle unless the receiver
//   stalls. A reserved operation code is dropped silently. The result sits in a
//   single output register; a new request is taken while that register is empty
//   or being drained in the same cycle. When the receiver stalls, the result
//   holds and s_tready drops. Reset empties the queue and clears the output;
//   memory contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_fifo_queue_with_dump
    import bfqd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] data, [37:32] occupancy, rest zero
    output logic [STAT_W-1:0]   m_tuser,   // [1:0] status
    output logic                m_tlast
);

    bfqd_cmd_t          cmd;
    bfqd_stat_t         stat;
    logic [VALUE_W-1:0] out_data;
    logic [OCC_W-1:0]   out_occ;

    bfqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_kind  (s_tuser),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfqd_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (s_tdata),
        .out_ready  (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_data   (out_data),
        .out_occ    (out_occ),
        .out_last   (m_tlast)
    );

    assign m_tdata = M_DATA_W'({out_occ, out_data});

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request taken while the result register is blocked");

    a_enq_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_ENQ) |=> (m_tvalid && m_tlast))
        else $error("enqueue did not produce a final result next cycle");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty together");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !cmd.wr)
        else $error("write issued into a full queue");

endmodule
